// ===== src/hpl_pkg.sv =====
package hpl_pkg;

    // field widths
    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int RADIUS_W = 23;
    localparam int SEG_W    = 25;
    localparam int TOTAL_W  = 31;
    localparam int MAG_W    = 31;
    localparam int UNIT_W   = 35;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6378137;
    localparam logic [SEG_W-1:0]    SEG_MAX      = '1;
    localparam logic [TOTAL_W-1:0]  TOTAL_CEIL   = '1;

    // fixed-point constants in Q62
    localparam logic [63:0] PI_Q62           = 64'hC90FDAA22168C234;
    localparam logic [63:0] GAIN_Q62         = 64'd2800459870029452954;
    localparam logic [63:0] RAD_PER_UNIT_Q62 = PI_Q62 / 64'd3600000000;

    // angles in units of 5e-8 degree
    localparam logic signed [UNIT_W-1:0] UNITS_FULL    = 35'sd7200000000;
    localparam logic signed [UNIT_W-1:0] UNITS_HALF    = 35'sd3600000000;
    localparam logic signed [UNIT_W-1:0] UNITS_QUARTER = 35'sd1800000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_ROT,
        ST_COMB,
        ST_SQRT,
        ST_VEC,
        ST_FIN
    } hpl_state_t;

    typedef enum logic [2:0] {
        OP_THETA,
        OP_CC,
        OP_PQ,
        OP_S1S1,
        OP_S2Q,
        OP_SCALE
    } hpl_op_t;

    typedef enum logic [1:0] {
        ANG_DLAT,
        ANG_DLON,
        ANG_LAT0,
        ANG_LAT1
    } hpl_ang_t;

    typedef enum logic [1:0] {
        MPH_IDLE,
        MPH_LOW,
        MPH_HIGH
    } hpl_mph_t;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem    = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q62 from its power series, each term truncated
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        int          e;
        pos = '0;
        neg = '0;
        if (i == 0) begin
            return PI_Q62 >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k[0]) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
        end
        return pos - neg;
    endfunction

endpackage

// ===== src/haversine_path_length.sv =====
// Haversine path length: great-circle length of a waypoint stream.
// Input channel s_*: one waypoint per transaction, latitude and longitude in
// 1e-7 degree in s_tdata, s_tuser high on the first point of a new path.
// Output channel m_*: exactly one result per waypoint, the segment length in
// whole metres (0 on a path start) and the saturating running total.
// cfg_we/cfg_wdata write the sphere radius in metres (reset 6378137).
// A path start, or the first point after reset, goes from acceptance straight
// to the result step. Any other point runs through four sine/cosine passes and
// one atan2 pass through the single CORDIC stage at one iteration a cycle, two
// bitwise square roots and nine products on a two-pass shared multiplier.
// s_tready is high only while the sequencer is idle, so one point is in work
// at a time. The finished result sits in an output register; the next point
// is taken while it waits, and the sequencer only holds at its last step if
// the previous result has still not been taken.
// Reset (aresetn low, synchronous) drops the output valid, forgets the previous
// point and clears the running total.
module haversine_path_length #(
    parameter int CORDIC_ITERS    = 32,
    parameter int ANGLE_FRAC_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // lat_e7[30:0], lon_e7[62:31]
    input  logic [0:0]                    s_tuser,   // path_start[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // segment_m[24:0], total_m[55:25],
                                                     // total_saturated[56]
    input  logic                          cfg_we,
    input  logic [hpl_pkg::RADIUS_W-1:0]  cfg_wdata
);
    import hpl_pkg::*;

    localparam int F    = ANGLE_FRAC_BITS;
    localparam int CW   = F + 3;
    localparam int MW   = (F + 2 > 32) ? F + 2 : 32;
    localparam int PW   = 2 * MW;
    localparam int SW   = 2 * F + 2;
    localparam int RW   = F + 4;
    localparam int RTW  = F + 1;
    localparam int CNTW = $clog2(CORDIC_ITERS);
    localparam int SQCW = $clog2(F + 1);

    typedef logic signed [CW-1:0] atan_tab_t [CORDIC_ITERS];

    function automatic atan_tab_t build_atan();
        atan_tab_t t;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            t[i] = CW'(atan_q62(i) >> (62 - F));
        end
        return t;
    endfunction

    function automatic logic [MW-1:0] mag_mw(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        return MW'(m);
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();
    localparam logic signed [CW-1:0] GAIN_F = CW'(GAIN_Q62 >> (62 - F));
    localparam logic [PW:0] ONE_Q = {{PW{1'b0}}, 1'b1} << (2 * F);

    hpl_state_t state_reg, state_next;
    hpl_op_t    op_reg;
    hpl_ang_t   ang_reg;

    logic                      have_prev_reg;
    logic signed [LAT_W-1:0]   prev_lat_reg;
    logic signed [LON_W-1:0]   prev_lon_reg;
    logic [TOTAL_W-1:0]        total_reg;
    logic [RADIUS_W-1:0]       radius_reg;
    logic                      m_tvalid_reg;
    logic [63:0]               m_tdata_reg;

    logic signed [LAT_W-1:0]   lat_reg;
    logic signed [LON_W-1:0]   lon_reg;
    logic                      restart_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic                      flip_reg;
    logic signed [CW-1:0]      x_reg, y_reg, z_reg;
    logic [CNTW-1:0]           cnt_reg;
    logic [MW-1:0]             s1m_reg, s2m_reg, c1m_reg, c2m_reg;
    logic                      c1neg_reg, c2neg_reg;
    logic [MW-1:0]             pmag_reg, q_reg;
    logic [PW-1:0]             a_reg, b_reg;
    logic [SW-1:0]             sq_opnd_reg;
    logic [RW-1:0]             rem_reg;
    logic [RTW-1:0]            root_reg, sa_reg;
    logic [SQCW-1:0]           sq_cnt_reg;
    logic                      sq_sel_reg;
    logic [SEG_W-1:0]          seg_reg;

    logic                      mul_start, mul_done;
    logic [MW-1:0]             mul_a, mul_b;
    logic [PW-1:0]             mul_p;

    logic signed [UNIT_W-1:0]  red_u, red_w, red_r;
    logic                      red_flip, red_neg;
    logic [MAG_W-1:0]          red_mag;

    logic signed [CW-1:0]      dx, dy, at, x_nx, y_nx, z_nx;
    logic                      sig_pos, cnt_last;

    logic [RW-1:0]             rem_sh, trial, rem_nx;
    logic                      sq_ge, sq_last;
    logic [RTW-1:0]            root_nx;

    logic [PW:0]               ab_sum, a_cl;
    logic [PW-1:0]             theta_full, seg_full;
    logic signed [CW-1:0]      theta;
    logic [SEG_W-1:0]          seg_sat;
    logic [TOTAL_W:0]          tot_sum;
    logic [TOTAL_W-1:0]        tot_new;
    logic                      out_free;
    logic signed [CW-1:0]      c_val;

    // shared multiplier
    hpl_mul #(.MW(MW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    // angle selection and exact quadrant reduction
    always_comb begin
        case (ang_reg)
            ANG_DLAT: red_u = UNIT_W'(lat_reg) - UNIT_W'(prev_lat_reg);
            ANG_DLON: red_u = UNIT_W'(lon_reg) - UNIT_W'(prev_lon_reg);
            ANG_LAT0: red_u = UNIT_W'(prev_lat_reg) <<< 1;
            ANG_LAT1: red_u = UNIT_W'(lat_reg) <<< 1;
            default:  red_u = '0;
        endcase
        if (red_u > UNITS_HALF) begin
            red_w = red_u - UNITS_FULL;
        end else if (red_u < -UNITS_HALF) begin
            red_w = red_u + UNITS_FULL;
        end else begin
            red_w = red_u;
        end
        red_flip = 1'b1;
        if (red_w > UNITS_QUARTER) begin
            red_r = UNITS_HALF - red_w;
        end else if (red_w < -UNITS_QUARTER) begin
            red_r = -UNITS_HALF - red_w;
        end else begin
            red_r    = red_w;
            red_flip = 1'b0;
        end
        red_neg = red_r[UNIT_W-1];
        red_mag = MAG_W'(red_neg ? -red_r : red_r);
    end

    // multiplier operand selection
    always_comb begin
        case (op_reg)
            OP_THETA: begin mul_a = MW'(mag_reg);    mul_b = MW'(RAD_PER_UNIT_Q62); end
            OP_CC:    begin mul_a = c1m_reg;         mul_b = c2m_reg;               end
            OP_PQ:    begin mul_a = pmag_reg;        mul_b = s2m_reg;               end
            OP_S1S1:  begin mul_a = s1m_reg;         mul_b = s1m_reg;               end
            OP_S2Q:   begin mul_a = s2m_reg;         mul_b = q_reg;                 end
            OP_SCALE: begin
                mul_a = MW'(radius_reg);
                mul_b = MW'({z_reg[CW-2:0], 1'b0});
            end
            default:  begin mul_a = '0;              mul_b = '0;                    end
        endcase
    end

    // cordic stage, rotation or vectoring
    always_comb begin
        dx       = y_reg >>> cnt_reg;
        dy       = x_reg >>> cnt_reg;
        at       = ATAN_TAB[cnt_reg];
        sig_pos  = (state_reg == ST_ROT) ? !z_reg[CW-1] : y_reg[CW-1];
        x_nx     = sig_pos ? x_reg - dx : x_reg + dx;
        y_nx     = sig_pos ? y_reg + dy : y_reg - dy;
        z_nx     = sig_pos ? z_reg - at : z_reg + at;
        cnt_last = (cnt_reg == CNTW'(CORDIC_ITERS - 1));
        c_val    = flip_reg ? -x_nx : x_nx;
    end

    // square root digit step
    always_comb begin
        rem_sh  = {rem_reg[RW-3:0], sq_opnd_reg[SW-1:SW-2]};
        trial   = RW'({root_reg, 2'b01});
        sq_ge   = (rem_sh >= trial);
        rem_nx  = sq_ge ? rem_sh - trial : rem_sh;
        root_nx = {root_reg[RTW-2:0], sq_ge};
        sq_last = (sq_cnt_reg == SQCW'(F));
    end

    // haversine term, product shifts and totals
    always_comb begin
        if (c1neg_reg != c2neg_reg) begin
            ab_sum = (a_reg < b_reg) ? '0 : ({1'b0, a_reg} - {1'b0, b_reg});
        end else begin
            ab_sum = {1'b0, a_reg} + {1'b0, b_reg};
        end
        a_cl       = (ab_sum > ONE_Q) ? ONE_Q : ab_sum;
        theta_full = mul_p >> (62 - F);
        theta      = CW'(theta_full);
        seg_full   = mul_p >> F;
        seg_sat    = (seg_full > PW'(SEG_MAX)) ? SEG_MAX : seg_full[SEG_W-1:0];
        tot_sum    = {1'b0, total_reg} + (TOTAL_W + 1)'(seg_reg);
        if (restart_reg) begin
            tot_new = '0;
        end else if (tot_sum > (TOTAL_W + 1)'(TOTAL_CEIL)) begin
            tot_new = TOTAL_CEIL;
        end else begin
            tot_new = tot_sum[TOTAL_W-1:0];
        end
        out_free = !m_tvalid_reg || m_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = (s_tuser[0] || !have_prev_reg) ? ST_FIN : ST_RED;
            end
            ST_RED:       state_next = ST_MUL_ISSUE;
            ST_MUL_ISSUE: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    case (op_reg)
                        OP_THETA: state_next = ST_ROT;
                        OP_S2Q:   state_next = ST_COMB;
                        OP_SCALE: state_next = ST_FIN;
                        default:  state_next = ST_MUL_ISSUE;
                    endcase
                end
            end
            ST_ROT: begin
                if (cnt_last) state_next = (ang_reg == ANG_LAT1) ? ST_MUL_ISSUE : ST_RED;
            end
            ST_COMB:      state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_last && sq_sel_reg) state_next = ST_VEC;
            end
            ST_VEC: begin
                if (cnt_last) state_next = ST_MUL_ISSUE;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        mul_start = (state_reg == ST_MUL_ISSUE);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            total_reg     <= '0;
            radius_reg    <= RADIUS_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) radius_reg <= cfg_wdata;
            if (state_reg == ST_FIN && out_free) begin
                m_tvalid_reg  <= 1'b1;
                total_reg     <= tot_new;
                prev_lat_reg  <= lat_reg;
                prev_lon_reg  <= lon_reg;
                have_prev_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    lat_reg     <= s_tdata[30:0];
                    lon_reg     <= s_tdata[62:31];
                    restart_reg <= s_tuser[0] || !have_prev_reg;
                    seg_reg     <= '0;
                    ang_reg     <= ANG_DLAT;
                end
            end
            ST_RED: begin
                mag_reg  <= red_mag;
                neg_reg  <= red_neg;
                flip_reg <= red_flip;
                op_reg   <= OP_THETA;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    case (op_reg)
                        OP_THETA: begin
                            x_reg   <= GAIN_F;
                            y_reg   <= '0;
                            z_reg   <= neg_reg ? -theta : theta;
                            cnt_reg <= '0;
                        end
                        OP_CC: begin
                            pmag_reg <= MW'(mul_p >> F);
                            op_reg   <= OP_PQ;
                        end
                        OP_PQ: begin
                            q_reg  <= MW'(mul_p >> F);
                            op_reg <= OP_S1S1;
                        end
                        OP_S1S1: begin
                            a_reg  <= mul_p;
                            op_reg <= OP_S2Q;
                        end
                        OP_S2Q:   b_reg   <= mul_p;
                        OP_SCALE: seg_reg <= seg_sat;
                        default: ;
                    endcase
                end
            end
            ST_ROT: begin
                x_reg   <= x_nx;
                y_reg   <= y_nx;
                z_reg   <= z_nx;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_last) begin
                    case (ang_reg)
                        ANG_DLAT: s1m_reg <= mag_mw(y_nx);
                        ANG_DLON: s2m_reg <= mag_mw(y_nx);
                        ANG_LAT0: begin
                            c1m_reg   <= mag_mw(c_val);
                            c1neg_reg <= c_val[CW-1];
                        end
                        ANG_LAT1: begin
                            c2m_reg   <= mag_mw(c_val);
                            c2neg_reg <= c_val[CW-1];
                        end
                        default: ;
                    endcase
                    ang_reg <= hpl_ang_t'(ang_reg + 1'b1);
                    op_reg  <= OP_CC;
                end
            end
            ST_COMB: begin
                a_reg       <= PW'(a_cl);
                b_reg       <= PW'(ONE_Q - a_cl);
                sq_opnd_reg <= SW'(a_cl);
                rem_reg     <= '0;
                root_reg    <= '0;
                sq_cnt_reg  <= '0;
                sq_sel_reg  <= 1'b0;
            end
            ST_SQRT: begin
                // first root done: keep it and restart on the complement
                if (sq_last && !sq_sel_reg) begin
                    sa_reg      <= root_nx;
                    sq_sel_reg  <= 1'b1;
                    sq_opnd_reg <= SW'(b_reg);
                    rem_reg     <= '0;
                    root_reg    <= '0;
                    sq_cnt_reg  <= '0;
                end else begin
                    rem_reg     <= rem_nx;
                    root_reg    <= root_nx;
                    sq_opnd_reg <= sq_opnd_reg << 2;
                    sq_cnt_reg  <= sq_cnt_reg + 1'b1;
                end
                if (sq_last && sq_sel_reg) begin
                    x_reg   <= CW'(root_nx);
                    y_reg   <= CW'(sa_reg);
                    z_reg   <= '0;
                    cnt_reg <= '0;
                end
            end
            ST_VEC: begin
                x_reg   <= x_nx;
                y_reg   <= y_nx;
                z_reg   <= (cnt_last && z_nx[CW-1]) ? '0 : z_nx;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_last) begin
                    op_reg <= OP_SCALE;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tdata_reg <= {7'b0, (tot_new == TOTAL_CEIL), tot_new, seg_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a path start goes straight to the result step
    a_restart_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] || !have_prev_reg)) |=> (state_reg == ST_FIN))
        else $error("path start did not go straight to the result step");

    // saturation flag agrees with the total
    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[56] == (m_tdata[55:25] == TOTAL_CEIL)))
        else $error("saturation flag disagrees with the total");

    // multiplier answers only while the sequencer waits for it
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL_WAIT))
        else $error("multiplier result outside the wait step");

    // a held result is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("held result changed");

endmodule

// ===== src/hpl_mul.sv =====
module hpl_mul #(
    parameter int MW = 34
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [MW-1:0]   a,
    input  logic [MW-1:0]   b,
    output logic            done,
    output logic [2*MW-1:0] p
);
    import hpl_pkg::*;

    localparam int HW = (MW + 1) / 2;
    localparam int PW = 2 * MW;

    hpl_mph_t              ph_reg;
    logic                  done_reg;
    logic [MW-1:0]         a_reg;
    logic [MW-1:0]         b_reg;
    logic [MW+HW-1:0]      acc_reg;
    logic [PW-1:0]         p_reg;
    logic [MW+HW-1:0]      lo_prod;
    logic [2*MW-HW-1:0]    hi_prod;

    // one half-width partial product per cycle
    assign lo_prod = a_reg * b_reg[HW-1:0];
    assign hi_prod = a_reg * b_reg[MW-1:HW];

    // phase sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= MPH_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (ph_reg == MPH_HIGH);
            case (ph_reg)
                MPH_IDLE: begin
                    if (start) ph_reg <= MPH_LOW;
                end
                MPH_LOW: begin
                    ph_reg <= MPH_HIGH;
                end
                MPH_HIGH: begin
                    ph_reg <= MPH_IDLE;
                end
                default: ph_reg <= MPH_IDLE;
            endcase
        end
    end

    // operands and accumulation
    always_ff @(posedge aclk) begin
        if (ph_reg == MPH_IDLE && start) begin
            a_reg <= a;
            b_reg <= b;
        end
        if (ph_reg == MPH_LOW) acc_reg <= lo_prod;
        if (ph_reg == MPH_HIGH) p_reg <= PW'(acc_reg) + (PW'(hi_prod) << HW);
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule
